>>> hw/rtl/skf_pkg.sv
// Shared widths, register indexes, reset values and command/status types for the Kalman filter.
`default_nettype none
package skf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COV_BITS    = 24;
  localparam int EST_BITS    = 32;
  localparam int GAIN_BITS   = 17;
  localparam int OUT_BITS    = 24;
  localparam int OUT_FRAC    = 8;
  localparam int CFG_BITS    = 24;
  localparam int IDX_BITS    = 2;
  localparam int DIV_STEPS   = 16;
  localparam int CNT_BITS    = 4;

  // register indexes of the configuration port
  localparam logic [IDX_BITS-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_INIT_COV      = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_INIT_EST      = 2'd3;

  // reset values
  localparam logic [COV_BITS-1:0]    RST_PROCESS_NOISE = 24'd49152;
  localparam logic [COV_BITS-1:0]    RST_MEASURE_NOISE = 24'd35586;
  localparam logic [COV_BITS-1:0]    RST_COV           = 24'd1311;
  localparam logic [SAMPLE_BITS-1:0] RST_EST_WHOLE     = 16'd1500;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic pred;      // form the predicted covariance
    logic div_init;  // set up the gain division
    logic div_step;  // one quotient bit
    logic mul;       // register both products
    logic upd;       // commit state and result
  } skf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // this division step produces the last quotient bit
  } skf_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/scalar_kalman_filter_unit.sv
// Top level of the one-dimensional fixed-point Kalman filter.
// Usage:
//   Input channel: sample with in_valid / in_stall. A word is taken at a clock
//   edge with in_valid high and in_stall low. in_stall is high while a sample
//   is being processed.
//   Output channel: estimate (signed, 8 fraction bits) and gain (Q1.16) with
//   out_valid / out_stall. One output word per input word, held stable while
//   out_stall is high. The result register lets the next sample be taken
//   while the previous result still waits.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
//   ready. Index 0 process noise, 1 measurement noise, 2 initial covariance
//   (reloads the covariance), 3 initial estimate (reloads the estimate).
//   Write only while the filter is idle.
//   Sequencing: a taken sample passes through prediction, divider setup, the
//   16-step radix-2 gain divider, the multiply and the update, which registers
//   the result. A new sample can be taken from the cycle after the result is
//   registered; no sample is taken while one is still being processed. A
//   stalled output holds the filter in the update state.
//   Reset: synchronous; configuration registers, filter state and sequencer
//   state return to their defaults, no output is pending.
`default_nettype none
module scalar_kalman_filter_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [skf_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [skf_pkg::OUT_BITS-1:0]         estimate,
  output logic [skf_pkg::GAIN_BITS-1:0]               gain,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [skf_pkg::IDX_BITS-1:0]           cfg_index,
  input  wire logic [skf_pkg::CFG_BITS-1:0]           cfg_data
);
  import skf_pkg::*;

  skf_cmd_t cmd;
  skf_sts_t sts;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  skf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .sts       (sts),
    .estimate  (estimate),
    .gain      (gain)
  );

  // an accepted sample keeps the input side busy next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not busy after accepting a sample");

  // the gain never exceeds one
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain <= GAIN_ONE))
    else $error("gain above one");

  // reset leaves no pending result
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // a new result is registered only while the filter is still busy
  assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !in_stall) |=> !out_valid)
    else $error("result appeared without work in progress");

endmodule
`default_nettype wire

>>> hw/rtl/skf_ctrl.sv
// Sequencing state machine and output handshake control for the Kalman filter.
`default_nettype none
module skf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire skf_pkg::skf_sts_t sts,
  output skf_pkg::skf_cmd_t   cmd
);
  import skf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRED = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  // result register can take a new word this cycle
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PRED;
        end
      end
      S_PRED: begin
        cmd.pred = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.upd = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/skf_dp.sv
// Datapath: config registers, filter state, radix-2 gain divider, two multipliers, result register.
`default_nettype none
module skf_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [skf_pkg::IDX_BITS-1:0]       cfg_index,
  input  wire logic [skf_pkg::CFG_BITS-1:0]       cfg_data,
  input  wire logic signed [skf_pkg::SAMPLE_BITS-1:0] sample,
  input  wire skf_pkg::skf_cmd_t                  cmd,
  output skf_pkg::skf_sts_t                       sts,
  output logic signed [skf_pkg::OUT_BITS-1:0]     estimate,
  output logic [skf_pkg::GAIN_BITS-1:0]           gain
);
  import skf_pkg::*;

  logic [COV_BITS-1:0]           q_noise;
  logic [COV_BITS-1:0]           r_noise;
  logic [COV_BITS-1:0]           cov;
  logic signed [EST_BITS-1:0]    est;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic [COV_BITS-1:0]           pred;
  logic [COV_BITS:0]             denom;
  logic [COV_BITS:0]             rem;
  logic [GAIN_BITS-1:0]          quo;
  logic [CNT_BITS-1:0]           cnt;
  logic signed [GAIN_BITS+EST_BITS+1:0] prod_est;
  logic [GAIN_BITS+COV_BITS-1:0] prod_cov;

  logic [COV_BITS:0]             pred_sum;
  logic [COV_BITS+1:0]           rem_sh;
  logic [COV_BITS+1:0]           rem_sub;
  logic                          q_bit;
  logic signed [EST_BITS:0]      diff;
  logic signed [EST_BITS-1:0]    est_next;
  logic                          q_top;

  // P + Q with saturation
  assign pred_sum = {1'b0, cov} + {1'b0, q_noise};

  // restoring division step: shift in a zero, subtract when it fits;
  // a zero denominator yields a zero quotient
  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, denom};
  assign q_bit   = !rem_sub[COV_BITS+1] && (denom != '0);

  // top quotient bit is set only when R is zero and the prediction is not
  assign q_top = (r_noise == '0) && (pred != '0);

  assign sts.div_last = (cnt == CNT_BITS'(DIV_STEPS - 1));

  // innovation in Q17.16 and the corrected estimate (floor of the shifted product)
  assign diff     = $signed({samp[SAMPLE_BITS-1], samp, {FRAC_BITS{1'b0}}})
                  - $signed({est[EST_BITS-1], est});
  assign est_next = est + prod_est[FRAC_BITS +: EST_BITS];

  // configuration registers and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= RST_PROCESS_NOISE;
      r_noise <= RST_MEASURE_NOISE;
      cov     <= RST_COV;
      est     <= {RST_EST_WHOLE, {FRAC_BITS{1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE: q_noise <= cfg_data;
        REG_MEASURE_NOISE: r_noise <= cfg_data;
        REG_INIT_COV:      cov     <= cfg_data;
        REG_INIT_EST:      est     <= {cfg_data[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
        default: begin
        end
      endcase
    end else if (cmd.upd) begin
      est <= est_next;
      cov <= prod_cov[FRAC_BITS +: COV_BITS];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp <= sample;
    end
    if (cmd.pred) begin
      pred <= pred_sum[COV_BITS] ? {COV_BITS{1'b1}} : pred_sum[COV_BITS-1:0];
    end
    if (cmd.div_init) begin
      denom <= {1'b0, pred} + {1'b0, r_noise};
      rem   <= q_top ? '0 : {1'b0, pred};
      quo   <= {{(GAIN_BITS-1){1'b0}}, q_top};
      cnt   <= '0;
    end else if (cmd.div_step) begin
      rem <= q_bit ? rem_sub[COV_BITS:0] : rem_sh[COV_BITS:0];
      quo <= {quo[GAIN_BITS-2:0], q_bit};
      cnt <= cnt + 1'b1;
    end
    if (cmd.mul) begin
      prod_est <= $signed({1'b0, quo}) * diff;
      prod_cov <= (GAIN_ONE - quo) * pred;
    end
    if (cmd.upd) begin
      estimate <= est_next[EST_BITS-1 -: OUT_BITS];
      gain     <= quo;
    end
  end

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the scalar Kalman filter unit.
module testbench;
  import skf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one filter output word
  typedef struct packed {
    logic signed [OUT_BITS-1:0] estimate;
    logic [GAIN_BITS-1:0]       gain;
  } filt_word_t;

  localparam int QUIET_LIMIT = 3000;  // cycles without any handshake
  localparam int SEG_ITEMS   = 85;
  localparam int SEG_COUNT   = 10;
  localparam int LONG_HOLD   = 300;

  // Filter predictor and store of expected output words.
  class kalman_scoreboard;
    logic [COV_BITS-1:0] q_noise;
    logic [COV_BITS-1:0] r_noise;
    logic [COV_BITS-1:0] cov;
    longint              est_q16;
    filt_word_t          expected_q[$];
    int                  errors;

    function new();
      q_noise = RST_PROCESS_NOISE;
      r_noise = RST_MEASURE_NOISE;
      cov     = RST_COV;
      est_q16 = longint'($signed(RST_EST_WHOLE)) <<< FRAC_BITS;
      errors  = 0;
    endfunction

    task report(string msg);
      $display("%s", msg);
      errors++;
    endtask

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_PROCESS_NOISE: q_noise = data;
        REG_MEASURE_NOISE: r_noise = data;
        REG_INIT_COV: cov = data;
        REG_INIT_EST: begin
          est_q16 = clamp(longint'($signed(data[SAMPLE_BITS-1:0])) <<< FRAC_BITS,
                          -64'sd2147483648, 64'sd2147483647);
        end
        default: ;
      endcase
    endfunction

    // One filter step for an accepted sample.
    function void note_sample(sample_t s);
      longint unsigned pred, denom, k;
      longint          target, diff, out_est;
      filt_word_t      w;
      pred = cov;
      pred += q_noise;
      if (pred > 64'hFFFFFF) pred = 64'hFFFFFF;
      denom = pred + r_noise;
      k = (denom == 0) ? 0 : (pred << 16) / denom;
      target = clamp(longint'(s) <<< FRAC_BITS, -64'sd2147483648, 64'sd2147483647);
      diff = target - est_q16;
      est_q16 = clamp(est_q16 + ((longint'(k) * diff) >>> 16),
                      -64'sd2147483648, 64'sd2147483647);
      cov = COV_BITS'(((64'd65536 - k) * pred) >> 16);
      out_est = clamp(est_q16 >>> (FRAC_BITS - OUT_FRAC), -64'sd8388608, 64'sd8388607);
      w.estimate = out_est[OUT_BITS-1:0];
      w.gain = k[GAIN_BITS-1:0];
      expected_q.push_back(w);
    endfunction

    task check_result(logic signed [OUT_BITS-1:0] e, logic [GAIN_BITS-1:0] g);
      filt_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word: estimate %0d gain %0d", e, g));
        return;
      end
      w = expected_q.pop_front();
      if (e !== w.estimate)
        report($sformatf("estimate mismatch: got %0d want %0d", e, w.estimate));
      if (g !== w.gain)
        report($sformatf("gain mismatch: got %0d want %0d", g, w.gain));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  sample_t                     sample;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [OUT_BITS-1:0]  estimate;
  logic [GAIN_BITS-1:0]        gain;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [IDX_BITS-1:0]         cfg_index;
  logic [CFG_BITS-1:0]         cfg_data;

  kalman_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int hold_left;
  int quiet_cycles;

  scalar_kalman_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .estimate  (estimate),
    .gain      (gain),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: check accepted words, random stalls, long hold-off on request.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(estimate, gain);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input sample_t s);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
  endtask

  task automatic send_list(input sample_t list[$]);
    foreach (list[i]) send_sample(list[i]);
  endtask

  // Wait until every expected word has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Idle-only register update; mask selects which registers are written.
  task automatic set_config(input logic [CFG_BITS-1:0] q, input logic [CFG_BITS-1:0] r,
                            input logic [CFG_BITS-1:0] p0, input logic [CFG_BITS-1:0] e0,
                            input logic [3:0] mask);
    drain_results();
    repeat (4) @(posedge clk);
    if (mask[0]) write_reg(REG_PROCESS_NOISE, q);
    if (mask[1]) write_reg(REG_MEASURE_NOISE, r);
    if (mask[2]) write_reg(REG_INIT_COV, p0);
    if (mask[3]) write_reg(REG_INIT_EST, e0);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_cov();
    case ($urandom_range(5))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return CFG_BITS'($urandom_range(255));
      3: return CFG_BITS'($urandom);
      default: return CFG_BITS'($urandom_range(200000));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return sample_t'($urandom_range(400)) - 16'sd200;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    hold_left = 0;
    quiet_cycles = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 45;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, sample extremes
    send_list('{32767, -32768, 0, -1, 1, 1500});
    // covariance saturates, estimate starts at the top with junk upper bits
    set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hA57FFF, 4'hF);
    send_list('{-32768, 32767, -32768});
    // zero denominator gives zero gain, estimate starts at the bottom
    set_config(24'h0, 24'h0, 24'h0, 24'h5A8000, 4'hF);
    send_list('{32767, 0});
    // no measurement noise: full gain
    set_config(24'h1, 24'h0, 24'h0, 24'h0, 4'h7);
    send_list('{-32768, 32767, 12345});
    // gain of one half, then zero once the covariance reaches zero
    set_config(24'h0, 24'h1, 24'h1, 24'h0, 4'h7);
    send_list('{-32768, 32767});
    // defaults, estimate starts at minus one
    set_config(RST_PROCESS_NOISE, RST_MEASURE_NOISE, RST_COV, 24'hFFFFFF, 4'hF);
    send_list('{-3, 5, -32768});

    // random segments; each rewrites a random subset of the settings (all in the first)
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg == 4) begin
        tx_idle_pct = 45;
        rx_idle_pct = 27;
      end else if (seg == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_config(pick_cov(), pick_cov(), pick_cov(), CFG_BITS'($urandom),
                 seg == 0 ? 4'hF : 4'($urandom));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // back up the output while samples keep coming
        if (seg == 1 && n == 20) hold_req = LONG_HOLD;
        // let the pipeline run dry mid-segment
        if (seg == 5 && n == 40) drain_results();
        send_sample(pick_sample());
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/skf_pkg.sv
hw/rtl/skf_ctrl.sv
hw/rtl/skf_dp.sv
hw/rtl/scalar_kalman_filter_unit.sv
sim/testbench.sv
